FILE: rtl/core/scr_pkg.sv
// types and codes shared by the sector cache clock replacement controller
`default_nettype none

package scr_pkg;

    localparam int SLOT_W   = 6;
    localparam int SECTOR_W = 32;

    // request opcodes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    // response kinds
    localparam logic [1:0] KIND_ACCESS    = 2'd0;
    localparam logic [1:0] KIND_FILL      = 2'd1;
    localparam logic [1:0] KIND_WRITEBACK = 2'd2;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [SECTOR_W-1:0] sector;
    } req_word_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [SLOT_W-1:0]   slot;
        logic [SECTOR_W-1:0] block_number;
        logic                hit;
        logic                last;
    } rsp_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SWEEP,
        ST_VICTIM,
        ST_VICTIM_WB,
        ST_FILL,
        ST_ACCESS,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/sector_cache_clock_replacement.sv
// top level: tag ram, slot status bits, clock hand and request sequencer
`default_nettype none

// Clock (second chance) tag and policy controller for a disk-sector buffer cache.
// Sector tags sit in a synchronous RAM (one read and one write per cycle, read
// data in the next cycle); valid, dirty and reference bits and the clock hand are
// flops. One request is worked on at a time. A read or write streams the tags
// out of the RAM one per cycle: a hit at slot i goes straight to the access
// that sends its word on rsp, a miss runs the whole lookup, then the clock hand
// sweep, then victim check, fill and access. A write adds a write-back scan,
// which a stalled response port can pause, and a flush is that scan alone;
// every request ends with a finish state that releases its last word.
// The response words leave through a one-word hold stage and an output
// register; a stalled response port pauses the sequencer. Opcode 3 is taken
// and ignored. No clearing pass is needed after reset.
module sector_cache_clock_replacement
    import scr_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_word_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_word_t      rsp
);

    localparam int SW = $clog2(SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

    function automatic rsp_word_t mk_word(
        input logic [1:0]          k,
        input logic [SW-1:0]       s,
        input logic [SECTOR_W-1:0] b,
        input logic                h
    );
        rsp_word_t w;
        w.kind         = k;
        w.slot         = SLOT_W'(s);
        w.block_number = b;
        w.hit          = h;
        w.last         = 1'b0;
        return w;
    endfunction

    // tag ram
    logic [SECTOR_W-1:0] tag_mem [SLOTS];
    logic [SECTOR_W-1:0] tag_q_reg;
    logic [SW-1:0]       mem_raddr;
    logic                mem_we;

    // control and status state
    state_t              state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [SECTOR_W-1:0] sector_reg, sector_next;
    logic [SW-1:0]       idx_reg, idx_next;
    logic [SW-1:0]       slot_reg, slot_next;
    logic                hit_reg, hit_next;
    logic [SW-1:0]       hand_reg, hand_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [SLOTS-1:0]    dirty_reg, dirty_next;
    logic [SLOTS-1:0]    ref_reg, ref_next;
    logic [SW-1:0]       tag_slot_reg;
    logic                tq_ok_reg;
    logic                rd_scan;

    // one-word hold stage, so the last flag can be set once the request ends
    rsp_word_t           pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    rsp_word_t           rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic                out_free;
    logic                emit_ok;
    logic                emit;
    rsp_word_t           emit_word;
    logic                push;
    rsp_word_t           push_word;
    logic                tq_hit;
    logic                tq_end;
    logic                tq_wb;
    logic                idx_end;
    logic [SW-1:0]       hand_inc;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign emit_ok  = !pend_valid_reg || out_free;
    assign tq_hit   = tq_ok_reg && valid_reg[tag_slot_reg] && (tag_q_reg == sector_reg);
    assign tq_end   = tq_ok_reg && (tag_slot_reg == LAST_SLOT);
    assign tq_wb    = tq_ok_reg && valid_reg[tag_slot_reg] && dirty_reg[tag_slot_reg];
    assign idx_end  = (idx_reg == LAST_SLOT);
    assign hand_inc = (hand_reg == LAST_SLOT) ? '0 : hand_reg + SW'(1);

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        sector_next     = sector_reg;
        idx_next        = idx_reg;
        slot_next       = slot_reg;
        hit_next        = hit_reg;
        hand_next       = hand_reg;
        valid_next      = valid_reg;
        dirty_next      = dirty_reg;
        ref_next        = ref_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        mem_raddr       = idx_reg;
        mem_we          = 1'b0;
        rd_scan         = 1'b0;
        emit            = 1'b0;
        emit_word       = pend_reg;
        push            = 1'b0;
        push_word       = pend_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req.opcode;
                    sector_next = req.sector;
                    idx_next    = '0;
                    if (req.opcode == OP_FLUSH)
                        state_next = ST_SCAN;
                    else if (req.opcode == OP_READ || req.opcode == OP_WRITE)
                        state_next = ST_LOOKUP;
                end
            end

            // one tag read issued per cycle, compared in the next cycle
            ST_LOOKUP:
            begin
                rd_scan   = 1'b1;
                mem_raddr = idx_reg;
                if (!idx_end)
                    idx_next = idx_reg + SW'(1);
                if (tq_hit)
                begin
                    slot_next  = tag_slot_reg;
                    hit_next   = 1'b1;
                    state_next = ST_ACCESS;
                end
                else if (tq_end)
                begin
                    hit_next   = 1'b0;
                    state_next = ST_SWEEP;
                end
            end

            // hand passes one slot a cycle, clearing reference bits
            ST_SWEEP:
            begin
                hand_next = hand_inc;
                if (!valid_reg[hand_reg] || !ref_reg[hand_reg])
                begin
                    slot_next  = hand_reg;
                    state_next = ST_VICTIM;
                end
                else
                begin
                    ref_next[hand_reg] = 1'b0;
                end
            end

            ST_VICTIM:
            begin
                mem_raddr  = slot_reg;
                state_next = ST_VICTIM_WB;
            end

            ST_VICTIM_WB:
            begin
                // keep the victim tag in the read register while waiting
                mem_raddr = slot_reg;
                if (valid_reg[slot_reg] && dirty_reg[slot_reg])
                begin
                    if (emit_ok)
                    begin
                        emit                 = 1'b1;
                        emit_word            = mk_word(KIND_WRITEBACK, slot_reg,
                                                       tag_q_reg, 1'b0);
                        dirty_next[slot_reg] = 1'b0;
                        state_next           = ST_FILL;
                    end
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end

            ST_FILL:
            begin
                if (emit_ok)
                begin
                    mem_we               = 1'b1;
                    valid_next[slot_reg] = 1'b1;
                    dirty_next[slot_reg] = 1'b0;
                    ref_next[slot_reg]   = 1'b1;
                    emit                 = 1'b1;
                    emit_word            = mk_word(KIND_FILL, slot_reg, sector_reg, 1'b0);
                    state_next           = ST_ACCESS;
                end
            end

            ST_ACCESS:
            begin
                if (emit_ok)
                begin
                    ref_next[slot_reg] = 1'b1;
                    emit               = 1'b1;
                    emit_word          = mk_word(KIND_ACCESS, slot_reg, sector_reg, hit_reg);
                    if (op_reg == OP_WRITE)
                    begin
                        dirty_next[slot_reg] = 1'b1;
                        idx_next             = '0;
                        state_next           = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            // write-back scan in slot order
            ST_SCAN:
            begin
                rd_scan = 1'b1;
                if (tq_wb && !emit_ok)
                begin
                    // re-read the same slot so its tag is still there next cycle
                    mem_raddr = tag_slot_reg;
                end
                else
                begin
                    mem_raddr = idx_reg;
                    if (!idx_end)
                        idx_next = idx_reg + SW'(1);
                    if (tq_wb)
                    begin
                        emit                     = 1'b1;
                        emit_word                = mk_word(KIND_WRITEBACK, tag_slot_reg,
                                                           tag_q_reg, 1'b0);
                        dirty_next[tag_slot_reg] = 1'b0;
                    end
                    if (tq_end)
                        state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (pend_valid_reg)
                begin
                    if (out_free)
                    begin
                        push            = 1'b1;
                        push_word.last  = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a new word pushes the held one out, not last
        if (emit)
        begin
            if (pend_valid_reg)
                push = 1'b1;
            pend_next       = emit_word;
            pend_valid_next = 1'b1;
        end

        rsp_next       = push ? push_word : rsp_reg;
        rsp_valid_next = push || (rsp_valid_reg && rsp_stall);
    end

    // tag ram, no reset
    always_ff @(posedge clk)
    begin
        if (mem_we)
            tag_mem[slot_reg] <= sector_reg;
        tag_q_reg <= tag_mem[mem_raddr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        sector_reg <= sector_next;
        slot_reg   <= slot_next;
        hit_reg    <= hit_next;
        pend_reg   <= pend_next;
        rsp_reg    <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            hand_reg       <= '0;
            valid_reg      <= '0;
            dirty_reg      <= '0;
            ref_reg        <= '0;
            tag_slot_reg   <= '0;
            tq_ok_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            hand_reg       <= hand_next;
            valid_reg      <= valid_next;
            dirty_reg      <= dirty_next;
            ref_reg        <= ref_next;
            tag_slot_reg   <= mem_raddr;
            tq_ok_reg      <= rd_scan;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // every write ends with all slots clean, so nothing is dirty between requests
    a_clean_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (dirty_reg == '0))
        else $error("dirty slot left after request");

    a_hold_empty_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("response word stranded in hold stage");

    a_hand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, hand_reg} < (SW + 1)'(SLOTS)))
        else $error("clock hand out of range");

    a_hit_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACCESS && hit_reg) |-> valid_reg[slot_reg])
        else $error("hit on an invalid slot");

endmodule

`default_nettype wire
